// ----- rtl/bpmt_pkg.sv -----
package bpmt_pkg;

	// Default table depth
	localparam int ENTRIES_DEF = 16;

	// Command codes
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_CHECK  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] space_root;
		logic [63:0] vaddr;
		logic [7:0]  bp_length;
		logic [2:0]  bp_type;
	} bpmt_cmd_t;

	typedef struct packed {
		logic       status;
		logic       hit;
		logic [7:0] hit_length;
		logic       space_new;
		logic       space_emptied;
	} bpmt_result_t;

	// Summary of one search pass over the table
	typedef struct packed {
		logic       key_found;
		logic [7:0] key_len;
		logic [2:0] key_type;
		logic       glob_found;
		logic [7:0] glob_len;
		logic [2:0] glob_type;
		logic       space_used;
		logic       space_other;
		logic       free_found;
	} bpmt_match_t;

	// Canonical form of a 48-bit virtual address
	function automatic logic [63:0] sext47(input logic [63:0] a);
		sext47 = {{16{a[47]}}, a[47:0]};
	endfunction

endpackage

// ----- rtl/bpmt_match.sv -----
module bpmt_match #(
	parameter int ENTRIES = bpmt_pkg::ENTRIES_DEF
) (
	input  logic [ENTRIES-1:0]       ent_valid,
	input  logic [ENTRIES-1:0][63:0] ent_space,
	input  logic [ENTRIES-1:0][63:0] ent_addr,
	input  logic [ENTRIES-1:0][7:0]  ent_len,
	input  logic [ENTRIES-1:0][2:0]  ent_type,
	input  logic [63:0]              space_root,
	input  logic [63:0]              key_addr,
	output logic [ENTRIES-1:0]       key_oh,
	output logic [ENTRIES-1:0]       free_oh,
	output bpmt_pkg::bpmt_match_t    info
);
	import bpmt_pkg::*;

	logic [ENTRIES-1:0] glob_m;
	logic [ENTRIES-1:0] space_m;
	logic [ENTRIES-1:0] free_v;

	// Compare every entry in parallel; keys are unique, so matches are one-hot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			space_m[i] = ent_valid[i] && (ent_space[i] == space_root);
			key_oh[i]  = space_m[i] && (ent_addr[i] == key_addr);
			glob_m[i]  = ent_valid[i] && (ent_space[i] == 64'd0) && (ent_addr[i] == key_addr);
		end
	end

	// Lowest free slot
	assign free_v  = ~ent_valid;
	assign free_oh = free_v & (~free_v + ENTRIES'(1));

	always_comb begin
		info = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			info.key_len   = info.key_len   | ({8{key_oh[i]}} & ent_len[i]);
			info.key_type  = info.key_type  | ({3{key_oh[i]}} & ent_type[i]);
			info.glob_len  = info.glob_len  | ({8{glob_m[i]}} & ent_len[i]);
			info.glob_type = info.glob_type | ({3{glob_m[i]}} & ent_type[i]);
		end
		info.key_found   = |key_oh;
		info.glob_found  = |glob_m;
		info.space_used  = |space_m;
		info.space_other = |(space_m & ~key_oh);
		info.free_found  = |free_v;
	end

endmodule

// ----- rtl/breakpoint_match_table_unit.sv -----
// Breakpoint match table: add, remove and check requests against a flop-based table.
// A request taken at a clock edge goes through the request register, then the result register, to done.
// Throughput: one request per cycle; busy stays low, as every request completes in one pass.
// One pass is a parallel compare of all entries followed by the table and result registers.
// Reset (arst_n low) empties the table and drops any request in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
module breakpoint_match_table_unit #(
	parameter int ENTRIES = bpmt_pkg::ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  bpmt_pkg::bpmt_cmd_t    cmd,
	output logic                   done,
	output bpmt_pkg::bpmt_result_t result
);
	import bpmt_pkg::*;

	// Request register
	logic         vld_s1;
	bpmt_cmd_t    cmd_s1;

	// Table storage
	logic [ENTRIES-1:0]       valid_q;
	logic [ENTRIES-1:0][63:0] space_q;
	logic [ENTRIES-1:0][63:0] addr_q;
	logic [ENTRIES-1:0][7:0]  len_q;
	logic [ENTRIES-1:0][2:0]  type_q;

	// Result register
	logic         done_q;
	bpmt_result_t result_q;

	logic [63:0]        key_addr;
	logic [ENTRIES-1:0] key_oh;
	logic [ENTRIES-1:0] free_oh;
	bpmt_match_t        info;
	bpmt_result_t       result_d;
	logic               do_add;
	logic               do_rem;
	logic               sp_nz;
	logic [ENTRIES-1:0] wr_new;
	logic [ENTRIES-1:0] wr_upd;
	logic [ENTRIES-1:0] wr_del;

	// Never stalls: every request finishes in its single pass
	assign busy = 1'b0;

	// Hold the accepted request for the compare pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
		end
	end

	// Add and remove work on the canonical address; a check uses it as given
	assign key_addr = (cmd_s1.kind == KIND_CHECK) ? cmd_s1.vaddr : sext47(cmd_s1.vaddr);
	assign sp_nz    = |cmd_s1.space_root;

	bpmt_match #(
		.ENTRIES(ENTRIES)
	) u_match (
		.ent_valid (valid_q),
		.ent_space (space_q),
		.ent_addr  (addr_q),
		.ent_len   (len_q),
		.ent_type  (type_q),
		.space_root(cmd_s1.space_root),
		.key_addr  (key_addr),
		.key_oh    (key_oh),
		.free_oh   (free_oh),
		.info      (info)
	);

	assign do_add = vld_s1 && (cmd_s1.kind == KIND_ADD);
	assign do_rem = vld_s1 && (cmd_s1.kind == KIND_REMOVE);

	// An add replaces the matching key in place, else claims the lowest free slot
	assign wr_new = {ENTRIES{do_add && !info.key_found}} & free_oh;
	assign wr_upd = {ENTRIES{do_add}} & (info.key_found ? key_oh : free_oh);
	assign wr_del = {ENTRIES{do_rem}} & key_oh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q | wr_new) & ~wr_del;
		end
	end

	// Entry payload is only read through a valid match, so it needs no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_new[i]) begin
				space_q[i] <= cmd_s1.space_root;
				addr_q[i]  <= key_addr;
			end
			if (wr_upd[i]) begin
				len_q[i]  <= cmd_s1.bp_length;
				type_q[i] <= cmd_s1.bp_type;
			end
		end
	end

	// Decode the request into its result; fields that do not apply stay zero
	always_comb begin
		result_d = '0;
		unique case (cmd_s1.kind)
			KIND_ADD: begin
				if (!info.key_found) begin
					if (info.free_found) begin
						result_d.space_new = sp_nz && !info.space_used;
					end else begin
						result_d.status = 1'b1;
					end
				end
			end
			KIND_REMOVE: begin
				result_d.space_emptied = info.key_found && sp_nz && !info.space_other;
			end
			KIND_CHECK: begin
				// Exact space first, then fall back to the global entry
				if (info.key_found && (info.key_type == cmd_s1.bp_type)) begin
					result_d.hit        = 1'b1;
					result_d.hit_length = info.key_len;
				end else if (info.glob_found && (info.glob_type == cmd_s1.bp_type)) begin
					result_d.hit        = 1'b1;
					result_d.hit_length = info.glob_len;
				end
			end
			default: begin
				result_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Keys stay unique, so at most one entry matches a given key
	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $onehot0(key_oh))
		else $error("more than one entry matches the request key");

	// Table full is reported only when every slot was taken
	a_full_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> $past(&valid_q))
		else $error("table full reported with a free slot");

	// A hit never comes with add or remove flags
	a_hit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (!result.status && !result.space_new && !result.space_emptied))
		else $error("hit reported alongside add or remove flags");

	// No hit means no length
	a_miss_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.hit_length == 8'd0))
		else $error("nonzero length without a hit");

	// A new space is flagged only when a free slot was filled
	a_new_space_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.space_new) |-> ($countones(valid_q) == $countones($past(valid_q)) + 1))
		else $error("new space flagged without filling a slot");

endmodule

// ----- verif/bpmt_scoreboard.sv -----
module bpmt_scoreboard (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  bpmt_pkg::bpmt_cmd_t    cmd,
	input  logic                   done,
	input  bpmt_pkg::bpmt_result_t result,
	output int                     outstanding,
	output int                     errors
);
	import bpmt_pkg::*;

	localparam int REPORT_MAX = 10;

	// Shadow copy of the breakpoint store
	logic        shadow_valid [ENTRIES_DEF];
	logic [63:0] shadow_space [ENTRIES_DEF];
	logic [63:0] shadow_addr  [ENTRIES_DEF];
	logic [7:0]  shadow_len   [ENTRIES_DEF];
	logic [2:0]  shadow_kind  [ENTRIES_DEF];

	bpmt_result_t due_results [$];
	int           mismatches;

	function automatic logic [63:0] canon48(input logic [63:0] a);
		if (a[47])
			return a | 64'hFFFF_0000_0000_0000;
		return a & 64'h0000_FFFF_FFFF_FFFF;
	endfunction

	function automatic int slot_of(input logic [63:0] sp, input logic [63:0] ad);
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (shadow_valid[i] && shadow_space[i] == sp && shadow_addr[i] == ad)
				return i;
		return -1;
	endfunction

	function automatic logic space_in_use(input logic [63:0] sp);
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (shadow_valid[i] && shadow_space[i] == sp)
				return 1'b1;
		return 1'b0;
	endfunction

	// Apply one request to the shadow store and return its outcome
	function automatic bpmt_result_t apply_request(input bpmt_cmd_t c);
		bpmt_result_t r;
		logic [63:0]  ad;
		int           slot;
		int           free_slot;
		r = '0;
		ad = canon48(c.vaddr);
		case (c.kind)
			KIND_ADD: begin
				slot = slot_of(c.space_root, ad);
				if (slot < 0) begin
					free_slot = -1;
					for (int i = ENTRIES_DEF - 1; i >= 0; i--)
						if (!shadow_valid[i])
							free_slot = i;
					slot = free_slot;
					if (slot < 0) begin
						r.status = 1'b1;
					end else begin
						if (c.space_root != 64'd0 && !space_in_use(c.space_root))
							r.space_new = 1'b1;
						shadow_valid[slot] = 1'b1;
						shadow_space[slot] = c.space_root;
						shadow_addr[slot]  = ad;
					end
				end
				if (slot >= 0) begin
					shadow_len[slot]  = c.bp_length;
					shadow_kind[slot] = c.bp_type;
				end
			end
			KIND_REMOVE: begin
				slot = slot_of(c.space_root, ad);
				if (slot >= 0) begin
					shadow_valid[slot] = 1'b0;
					shadow_space[slot] = '0;
					shadow_addr[slot]  = '0;
					shadow_len[slot]   = '0;
					shadow_kind[slot]  = '0;
					if (c.space_root != 64'd0 && !space_in_use(c.space_root))
						r.space_emptied = 1'b1;
				end
			end
			KIND_CHECK: begin
				// exact space first, then a global entry at the raw address
				slot = slot_of(c.space_root, c.vaddr);
				if (slot >= 0 && shadow_kind[slot] != c.bp_type)
					slot = -1;
				if (slot < 0) begin
					slot = slot_of(64'd0, c.vaddr);
					if (slot >= 0 && shadow_kind[slot] != c.bp_type)
						slot = -1;
				end
				if (slot >= 0) begin
					r.hit        = 1'b1;
					r.hit_length = shadow_len[slot];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	assign outstanding = due_results.size();
	assign errors      = mismatches;

	always @(posedge clk or negedge arst_n) begin
		bpmt_result_t want;
		logic         bad;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES_DEF; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_space[i] = '0;
				shadow_addr[i]  = '0;
				shadow_len[i]   = '0;
				shadow_kind[i]  = '0;
			end
			due_results.delete();
			mismatches = 0;
		end else begin
			if (start && !busy)
				due_results.push_back(apply_request(cmd));
			if (done) begin
				if (due_results.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: result %h with no request waiting", $realtime, result);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					bad = (result.status !== want.status) || (result.hit !== want.hit)
						|| (result.hit_length !== want.hit_length)
						|| (result.space_new !== want.space_new)
						|| (result.space_emptied !== want.space_emptied);
					if (bad) begin
						if (mismatches < REPORT_MAX)
							$display("%0t: st/hit/len/new/gone want %b %b %h %b %b got %b %b %h %b %b",
								$realtime, want.status, want.hit, want.hit_length,
								want.space_new, want.space_emptied, result.status,
								result.hit, result.hit_length, result.space_new,
								result.space_emptied);
						mismatches++;
					end
				end
			end
		end
	end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	import bpmt_pkg::*;

	// Kind value the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1000;
	localparam int CYCLE_LIMIT     = 100000;
	localparam int TAIL_CYCLES     = 8;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	bpmt_cmd_t    cmd;
	logic         done;
	bpmt_result_t result;
	int           outstanding;
	int           errors;
	int           cycles;

	// Pools of keys, kept small so the table fills, empties and hits often
	logic [63:0] space_pool [6];
	logic [63:0] addr_pool  [8];

	breakpoint_match_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	bpmt_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.outstanding (outstanding),
		.errors      (errors)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: abandon the run if it ever hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("breakpoint_match_table_unit regression: fail");
			$finish;
		end
	end

	function automatic bpmt_cmd_t make_cmd(input logic [1:0] k, input logic [63:0] sp,
		input logic [63:0] va, input logic [7:0] len, input logic [2:0] ty);
		bpmt_cmd_t c;
		c.kind       = k;
		c.space_root = sp;
		c.vaddr      = va;
		c.bp_length  = len;
		c.bp_type    = ty;
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one request from the falling edge and hold it until the block takes it.
	// Start stays high into the next request unless an idle gap is drawn.
	task automatic send_request(input bpmt_cmd_t c, input bit may_idle);
		int gap;
		gap = 0;
		if (may_idle && $urandom_range(0, 99) < 10)
			gap = $urandom_range(1, 4);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			cmd   <= bpmt_cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		end
		@(negedge clk);
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Build one random request around the key pools.
	// Addresses for add and remove get random upper bits half the time, which the block must discard;
	// checks mostly use the canonical form so that stored entries are found.
	function automatic bpmt_cmd_t random_request(input int add_share);
		bpmt_cmd_t   c;
		int          pick;
		int          ai;
		logic [63:0] va;
		logic [2:0]  ty;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return bpmt_cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		ai = $urandom_range(0, 7);
		va = addr_pool[ai];
		ty = ($urandom_range(0, 9) < 7) ? 3'(ai % 5) : 3'($urandom_range(0, 7));
		c = make_cmd(KIND_ADD, space_pool[($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5)],
			va, 8'($urandom_range(0, 255)), ty);
		pick = $urandom_range(0, 99);
		if (pick < add_share) begin
			c.kind = KIND_ADD;
		end else if (pick < add_share + (100 - add_share) * 2 / 5) begin
			c.kind = KIND_REMOVE;
		end else if (pick < 97) begin
			c.kind = KIND_CHECK;
		end else begin
			c.kind = KIND_UNUSED;
		end
		if (c.kind != KIND_CHECK && $urandom_range(0, 1))
			c.vaddr[63:48] = 16'($urandom);
		else if (c.kind == KIND_CHECK && $urandom_range(0, 4) == 0)
			c.vaddr[63:48] = ~c.vaddr[63:48];
		return c;
	endfunction

	initial begin
		logic [63:0] lo;
		int          add_share;
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;

		space_pool[0] = 64'd0;
		space_pool[1] = '1;
		for (int i = 2; i < 6; i++)
			space_pool[i] = rand64();
		for (int i = 0; i < 8; i++) begin
			lo = rand64();
			if (i < 2)
				lo[47] = i[0];
			addr_pool[i] = {{16{lo[47]}}, lo[47:0]};
		end

		// Hold reset, then release it on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a global entry, then a spaced entry at an address with bit 47 set
		send_request(make_cmd(KIND_ADD, 64'd0, 64'd0, 8'h00, 3'd0), 1'b0);
		send_request(make_cmd(KIND_ADD, 64'h1000, 64'h0000_8000_0000_0000, 8'hFF, 3'd4), 1'b0);
		// Check at the extended address hits; the raw form does not
		send_request(make_cmd(KIND_CHECK, 64'h1000, 64'hFFFF_8000_0000_0000, 8'h00, 3'd4), 1'b0);
		send_request(make_cmd(KIND_CHECK, 64'h1000, 64'h0000_8000_0000_0000, 8'h00, 3'd4), 1'b0);
		// Fall back to the global entry from another space, and search with space zero
		send_request(make_cmd(KIND_CHECK, 64'h2000, 64'd0, 8'h00, 3'd0), 1'b0);
		send_request(make_cmd(KIND_CHECK, 64'd0, 64'd0, 8'h00, 3'd0), 1'b0);
		// Type mismatch misses
		send_request(make_cmd(KIND_CHECK, 64'h1000, 64'hFFFF_8000_0000_0000, 8'h00, 3'd3), 1'b0);
		// Replace in place with type 7, then find it
		send_request(make_cmd(KIND_ADD, 64'h1000, 64'h1234_8000_0000_0000, 8'h07, 3'd7), 1'b0);
		send_request(make_cmd(KIND_CHECK, 64'h1000, 64'hFFFF_8000_0000_0000, 8'h00, 3'd7), 1'b0);
		// Unknown kind with every field at its top
		send_request(make_cmd(KIND_UNUSED, '1, '1, 8'hFF, 3'd7), 1'b0);
		// Remove an absent key, then the last entry of a space
		send_request(make_cmd(KIND_REMOVE, 64'h2000, 64'd0, 8'h00, 3'd0), 1'b0);
		send_request(make_cmd(KIND_REMOVE, 64'h1000, 64'h0000_8000_0000_0000, 8'h00, 3'd0), 1'b0);
		// Fill the table from the top space, then overflow it with a new key
		for (int i = 0; i < ENTRIES_DEF; i++)
			send_request(make_cmd(KIND_ADD, '1, {48'hFFFF_FFFF_FFFF, 16'(i)}, 8'h55,
				3'(i % 5)), 1'b0);
		send_request(make_cmd(KIND_CHECK, '1, '1, 8'h00, 3'd0), 1'b0);
		// Remove the global entry so random traffic starts from a known mix
		send_request(make_cmd(KIND_REMOVE, 64'd0, 64'd0, 8'h00, 3'd0), 1'b0);

		// Random traffic; the add share moves every hundred requests so the table
		// swings between nearly empty and full
		add_share = 50;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0)
				add_share = $urandom_range(20, 75);
			send_request(random_request(add_share), !(n >= 300 && n < 550));
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain: wait for every result, then linger past the block latency
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("breakpoint_match_table_unit regression: pass");
		else
			$display("breakpoint_match_table_unit regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/bpmt_pkg.sv
rtl/bpmt_match.sv
rtl/breakpoint_match_table_unit.sv
verif/bpmt_scoreboard.sv
verif/tb_top.sv
